// ===== rtl/lfu_pkg.sv =====
package lfu_pkg;

    localparam int KEY_W   = 32;
    localparam int DATA_W  = 32;
    localparam int COUNT_W = 16;
    localparam int TOUCH_W = 64;
    localparam int CAP_W   = 5;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = '1;
    localparam logic [DATA_W-1:0]  MISS_VALUE = '1;

    localparam logic MODE_GET = 1'b0;
    localparam logic MODE_PUT = 1'b1;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // One stored entry as it sits in the entry memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [DATA_W-1:0]  data;
        logic [COUNT_W-1:0] count;
        logic [TOUCH_W-1:0] touch;
    } t_entry;

    // What a completed pass over the entries has found.
    typedef struct packed {
        logic match;
        logic free;
        logic victim;
    } t_scan_flags;

endpackage

// ===== rtl/lfu_cache_replacement.sv =====
// Channel  | Direction | Handshake            | Word
// ---------+-----------+----------------------+----------------------------------
// command  | in        | start & !busy        | i_mode, i_key, i_value
// result   | out       | o_done (one cycle)   | o_read_value, o_hit, o_evicted
// config   | in        | i_cfg_we             | i_cfg_wdata (capacity)
//
// A command is accepted in idle, then the scan state reads the entry memory once
// per entry over one read port, then the decision state writes back. The result
// strobe comes in the cycle after the write-back, which is also the first cycle
// a new command is taken. Reset is synchronous; it clears the valid bits,
// occupancy and the touch counter, so no clearing pass is needed. The receiver
// cannot stall.
module lfu_cache_replacement #(
    parameter int ENTRIES = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_mode,
    input  logic signed [31:0]            i_key,
    input  logic signed [31:0]            i_value,
    input  logic                          i_cfg_we,
    input  logic [lfu_pkg::CAP_W-1:0]     i_cfg_wdata,
    output logic                          o_done,
    output logic signed [31:0]            o_read_value,
    output logic                          o_hit,
    output logic                          o_evicted
);

    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int OW = $clog2(ENTRIES + 1);
    localparam int CW = (OW > lfu_pkg::CAP_W) ? OW : lfu_pkg::CAP_W;
    localparam logic [AW-1:0] LAST_IDX = AW'(ENTRIES - 1);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_DECIDE = 2'd2;

    logic [1:0]                     r_state;
    logic [lfu_pkg::CAP_W-1:0]      r_cap;
    logic [ENTRIES-1:0]             r_valid;
    logic [OW-1:0]                  r_occ;
    logic [lfu_pkg::TOUCH_W-1:0]    r_time;
    logic                           r_mode;
    logic [lfu_pkg::KEY_W-1:0]      r_key;
    logic [lfu_pkg::DATA_W-1:0]     r_value;
    logic [AW-1:0]                  r_addr;
    logic                           r_issue;
    logic                           r_rd_vld;
    logic [AW-1:0]                  r_rd_idx;
    logic                           r_done;
    logic [lfu_pkg::DATA_W-1:0]     r_read_value;
    logic                           r_hit;
    logic                           r_evicted;

    logic                           accept;
    lfu_pkg::t_entry                rd_entry;
    lfu_pkg::t_scan_flags           flags;
    logic [AW-1:0]                  match_idx;
    lfu_pkg::t_entry                match_entry;
    logic [AW-1:0]                  free_idx;
    logic [AW-1:0]                  victim_idx;

    logic                           n_we;
    logic [AW-1:0]                  n_waddr;
    lfu_pkg::t_entry                n_wentry;
    logic                           n_set_valid;
    logic                           n_occ_inc;
    logic [lfu_pkg::DATA_W-1:0]     n_read_value;
    logic                           n_hit;
    logic                           n_evicted;
    logic                           fill;
    logic [lfu_pkg::COUNT_W-1:0]    bumped;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    lfu_mem #(.ENTRIES(ENTRIES), .AW(AW)) u_mem (
        .i_clk   (i_clk),
        .i_we    (n_we),
        .i_waddr (n_waddr),
        .i_wdata (n_wentry),
        .i_raddr (r_addr),
        .o_rdata (rd_entry)
    );

    lfu_scan #(.AW(AW)) u_scan (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_clear       (accept),
        .i_vld         (r_rd_vld),
        .i_idx         (r_rd_idx),
        .i_entry_valid (r_valid[r_rd_idx]),
        .i_entry       (rd_entry),
        .i_key         (r_key),
        .o_flags       (flags),
        .o_match_idx   (match_idx),
        .o_match_entry (match_entry),
        .o_free_idx    (free_idx),
        .o_victim_idx  (victim_idx)
    );

    // Occupancy never exceeds ENTRIES, so a free slot below capacity also
    // covers capacities written above the entry count.
    assign fill   = (CW'(r_occ) < CW'(r_cap)) && flags.free;
    assign bumped = (match_entry.count < lfu_pkg::COUNT_MAX) ?
                    match_entry.count + 1'b1 : match_entry.count;

    always_comb begin
        n_we         = 1'b0;
        n_waddr      = match_idx;
        n_wentry     = match_entry;
        n_set_valid  = 1'b0;
        n_occ_inc    = 1'b0;
        n_read_value = lfu_pkg::MISS_VALUE;
        n_hit        = 1'b0;
        n_evicted    = 1'b0;
        if (r_state == S_DECIDE) begin
            if (flags.match && (r_mode == lfu_pkg::MODE_GET || r_cap != '0)) begin
                n_we           = 1'b1;
                n_hit          = 1'b1;
                n_wentry.count = bumped;
                n_wentry.touch = r_time;
                if (r_mode == lfu_pkg::MODE_GET) begin
                    n_read_value = match_entry.data;
                end else begin
                    n_wentry.data = r_value;
                end
            end else if (r_mode == lfu_pkg::MODE_PUT && r_cap != '0) begin
                n_we           = 1'b1;
                n_set_valid    = 1'b1;
                n_occ_inc      = fill;
                n_evicted      = !fill;
                n_waddr        = fill ? free_idx : victim_idx;
                n_wentry.key   = r_key;
                n_wentry.data  = r_value;
                n_wentry.count = lfu_pkg::COUNT_W'(1);
                n_wentry.touch = r_time;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cap    <= lfu_pkg::CAP_RESET;
            r_valid  <= '0;
            r_occ    <= '0;
            r_time   <= '0;
            r_issue  <= 1'b0;
            r_rd_vld <= 1'b0;
            r_done   <= 1'b0;
            r_addr   <= '0;
        end else begin
            r_done   <= 1'b0;
            r_rd_vld <= r_issue;
            r_rd_idx <= r_addr;
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= S_SCAN;
                        r_addr  <= '0;
                        r_issue <= 1'b1;
                        r_mode  <= i_mode;
                        r_key   <= i_key;
                        r_value <= i_value;
                    end
                end
                S_SCAN: begin
                    if (r_issue) begin
                        if (r_addr == LAST_IDX) begin
                            r_issue <= 1'b0;
                        end else begin
                            r_addr <= r_addr + 1'b1;
                        end
                    end
                    if (r_rd_vld && r_rd_idx == LAST_IDX) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_state      <= S_IDLE;
                    r_done       <= 1'b1;
                    r_read_value <= n_read_value;
                    r_hit        <= n_hit;
                    r_evicted    <= n_evicted;
                    if (n_we) begin
                        r_time <= r_time + 1'b1;
                    end
                    if (n_set_valid) begin
                        r_valid[n_waddr] <= 1'b1;
                    end
                    if (n_occ_inc) begin
                        r_occ <= r_occ + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_done       = r_done;
    assign o_read_value = r_read_value;
    assign o_hit        = r_hit;
    assign o_evicted    = r_evicted;

    a_occ_matches_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(r_valid) == 32'(r_occ))
        else $error("occupancy does not match the number of valid entries");

    a_evict_only_on_put_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_evicted) |-> (!o_hit && r_mode == lfu_pkg::MODE_PUT))
        else $error("eviction reported outside a missing put");

    a_miss_reads_minus_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_read_value == lfu_pkg::MISS_VALUE))
        else $error("miss returned a value other than minus one");

    a_done_after_decide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DECIDE) |=> (o_done && !busy))
        else $error("result strobe missing after the decision cycle");

endmodule

// ===== rtl/lfu_mem.sv =====
module lfu_mem #(
    parameter int ENTRIES = 16,
    parameter int AW      = 4
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  lfu_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output lfu_pkg::t_entry o_rdata
);

    lfu_pkg::t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/lfu_scan.sv =====
module lfu_scan #(
    parameter int AW = 4
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_clear,
    input  logic                    i_vld,
    input  logic [AW-1:0]           i_idx,
    input  logic                    i_entry_valid,
    input  lfu_pkg::t_entry         i_entry,
    input  logic [lfu_pkg::KEY_W-1:0] i_key,
    output lfu_pkg::t_scan_flags    o_flags,
    output logic [AW-1:0]           o_match_idx,
    output lfu_pkg::t_entry         o_match_entry,
    output logic [AW-1:0]           o_free_idx,
    output logic [AW-1:0]           o_victim_idx
);

    lfu_pkg::t_scan_flags                r_flags;
    logic [AW-1:0]                       r_match_idx;
    lfu_pkg::t_entry                     r_match_entry;
    logic [AW-1:0]                       r_free_idx;
    logic [AW-1:0]                       r_victim_idx;
    logic [lfu_pkg::COUNT_W-1:0]         r_victim_count;
    logic [lfu_pkg::TOUCH_W-1:0]         r_victim_touch;
    logic                                older;

    // Lower count wins; on equal counts the older touch wins. Strict compare
    // keeps the lowest index among exact ties.
    assign older = (i_entry.count < r_victim_count) ||
                   ((i_entry.count == r_victim_count) && (i_entry.touch < r_victim_touch));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_flags <= '0;
        end else if (i_vld) begin
            if (i_entry_valid && (i_entry.key == i_key) && !r_flags.match) begin
                r_flags.match <= 1'b1;
                r_match_idx   <= i_idx;
                r_match_entry <= i_entry;
            end
            if (!i_entry_valid && !r_flags.free) begin
                r_flags.free <= 1'b1;
                r_free_idx   <= i_idx;
            end
            if (i_entry_valid && (!r_flags.victim || older)) begin
                r_flags.victim <= 1'b1;
                r_victim_idx   <= i_idx;
                r_victim_count <= i_entry.count;
                r_victim_touch <= i_entry.touch;
            end
        end
    end

    assign o_flags       = r_flags;
    assign o_match_idx   = r_match_idx;
    assign o_match_entry = r_match_entry;
    assign o_free_idx    = r_free_idx;
    assign o_victim_idx  = r_victim_idx;

endmodule

// ===== tb/lfu_cache_replacement_test.sv =====
`timescale 1ns / 1ps

module lfu_cache_replacement_test;

    localparam int SLOTS        = 16;
    localparam int TAIL_CYCLES  = 2 * (SLOTS + 3);
    localparam int CYCLE_LIMIT  = 6000000;
    localparam int PRINT_LIMIT  = 40;

    typedef enum logic [1:0] {
        OP_WORD,
        OP_CAPACITY,
        OP_DRAIN
    } t_op_kind;

    typedef struct packed {
        t_op_kind                   kind;
        logic                       mode;
        logic signed [31:0]         key;
        logic signed [31:0]         value;
        logic [lfu_pkg::CAP_W-1:0]  cap;
        logic [2:0]                 idle;
    } t_cache_op;

    typedef struct packed {
        logic signed [31:0] read_value;
        logic               hit;
        logic               evicted;
    } t_outcome;

    logic                     i_clk       = 1'b0;
    logic                     i_rst_n     = 1'b0;
    logic                     start       = 1'b0;
    logic                     i_mode      = lfu_pkg::MODE_GET;
    logic signed [31:0]       i_key       = '0;
    logic signed [31:0]       i_value     = '0;
    logic                     i_cfg_we    = 1'b0;
    logic [lfu_pkg::CAP_W-1:0] i_cfg_wdata = '0;
    logic                     busy;
    logic                     o_done;
    logic signed [31:0]       o_read_value;
    logic                     o_hit;
    logic                     o_evicted;

    lfu_cache_replacement #(
        .ENTRIES(SLOTS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_mode(i_mode),
        .i_key(i_key),
        .i_value(i_value),
        .i_cfg_we(i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .o_done(o_done),
        .o_read_value(o_read_value),
        .o_hit(o_hit),
        .o_evicted(o_evicted)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Shadow copy of the cache contents.
    logic                          slot_valid [SLOTS];
    logic [lfu_pkg::KEY_W-1:0]     slot_key   [SLOTS];
    logic [lfu_pkg::DATA_W-1:0]    slot_data  [SLOTS];
    logic [lfu_pkg::COUNT_W-1:0]   slot_count [SLOTS];
    logic [lfu_pkg::TOUCH_W-1:0]   slot_touch [SLOTS];
    logic [lfu_pkg::CAP_W-1:0]     cache_capacity = lfu_pkg::CAP_RESET;
    int                            fill = 0;
    logic [lfu_pkg::TOUCH_W-1:0]   touch_clock = '0;

    t_cache_op   pending_ops[$];
    t_outcome    pending_results[$];
    logic signed [31:0] key_pool [20];

    int cycle_count   = 0;
    int words_out     = 0;
    int mismatches    = 0;
    int get_count     = 0;
    int put_count     = 0;
    int hit_count     = 0;
    int evict_count   = 0;
    int setting_count = 0;

    function automatic int free_slot();
        int i;
        for (i = 0; i < SLOTS; i++)
            if (!slot_valid[i])
                return i;
        return -1;
    endfunction

    function automatic void touch_hit(int s);
        if (slot_count[s] != lfu_pkg::COUNT_MAX)
            slot_count[s] = slot_count[s] + 1'b1;
        slot_touch[s] = touch_clock;
        touch_clock   = touch_clock + 1'b1;
    endfunction

    function automatic t_outcome predict_access(logic mode, logic [31:0] k, logic [31:0] v);
        t_outcome res;
        int       room;
        int       slot;
        int       i;
        res.read_value = lfu_pkg::MISS_VALUE;
        res.hit        = 1'b0;
        res.evicted    = 1'b0;
        room = (cache_capacity > SLOTS) ? SLOTS : int'(cache_capacity);
        slot = -1;
        for (i = SLOTS - 1; i >= 0; i--)
            if (slot_valid[i] && slot_key[i] == k)
                slot = i;
        if (mode == lfu_pkg::MODE_GET) begin
            if (slot >= 0) begin
                res.read_value = slot_data[slot];
                res.hit        = 1'b1;
                touch_hit(slot);
            end
        end else if (room != 0) begin
            if (slot >= 0) begin
                res.hit         = 1'b1;
                slot_data[slot] = v;
                touch_hit(slot);
            end else begin
                if (fill < room)
                    slot = free_slot();
                if (slot < 0) begin
                    // Lowest count wins, the oldest touch breaks a tie.
                    for (i = 0; i < SLOTS; i++)
                        if (slot_valid[i] && (slot < 0 || slot_count[i] < slot_count[slot] ||
                            (slot_count[i] == slot_count[slot] &&
                             slot_touch[i] < slot_touch[slot])))
                            slot = i;
                    if (slot >= 0) begin
                        slot_valid[slot] = 1'b0;
                        if (fill > 0)
                            fill--;
                        res.evicted = 1'b1;
                    end else begin
                        slot = free_slot();
                    end
                end
                if (slot >= 0) begin
                    slot_valid[slot] = 1'b1;
                    slot_key[slot]   = k;
                    slot_data[slot]  = v;
                    slot_count[slot] = 1;
                    slot_touch[slot] = touch_clock;
                    touch_clock      = touch_clock + 1'b1;
                    fill++;
                end
            end
        end
        return res;
    endfunction

    task automatic flag_mismatch(string msg);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] mismatch: %s", $realtime, msg);
        mismatches++;
    endtask

    task automatic check_result();
        t_outcome want;
        if (pending_results.size() == 0) begin
            flag_mismatch("result word with nothing outstanding");
            return;
        end
        want = pending_results.pop_front();
        if (o_read_value !== want.read_value)
            flag_mismatch($sformatf("read_value %h, expected %h", o_read_value,
                                    want.read_value));
        if (o_hit !== want.hit)
            flag_mismatch($sformatf("hit %b, expected %b", o_hit, want.hit));
        if (o_evicted !== want.evicted)
            flag_mismatch($sformatf("evicted %b, expected %b", o_evicted, want.evicted));
    endtask

    task automatic queue_word(logic mode, logic signed [31:0] key, logic signed [31:0] value,
                              int idle);
        t_cache_op op;
        op.kind  = OP_WORD;
        op.mode  = mode;
        op.key   = key;
        op.value = value;
        op.cap   = '0;
        op.idle  = idle[2:0];
        pending_ops.push_back(op);
    endtask

    task automatic queue_control(t_op_kind kind, logic [lfu_pkg::CAP_W-1:0] cap);
        t_cache_op op;
        op       = '0;
        op.kind  = kind;
        op.cap   = cap;
        pending_ops.push_back(op);
        if (kind == OP_CAPACITY)
            setting_count++;
    endtask

    // Mostly keys from a small pool so that hits, updates and evictions occur.
    task automatic queue_random_words(int count, int window, bit with_idle);
        int                 n;
        logic               mode;
        logic signed [31:0] key;
        int                 idle;
        for (n = 0; n < count; n++) begin
            mode = ($urandom_range(0, 1) == 1) ? lfu_pkg::MODE_PUT : lfu_pkg::MODE_GET;
            key  = ($urandom_range(0, 6) == 0) ? $urandom : key_pool[$urandom_range(0, window - 1)];
            idle = (with_idle && $urandom_range(0, 2) == 0) ? $urandom_range(1, 6) : 0;
            queue_word(mode, key, $urandom, idle);
            if ($urandom_range(0, 149) == 0)
                queue_control(OP_DRAIN, '0);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Driver: presents words from the pending queue and writes capacity when idle.
    int idle_left = 0;

    always @(posedge i_clk) begin
        t_cache_op head;
        logic      accepted;
        logic      nxt_start;
        logic      nxt_we;
        if (!i_rst_n) begin
            start     <= 1'b0;
            i_cfg_we  <= 1'b0;
            words_out = 0;
            idle_left = 0;
        end else begin
            accepted  = start && !busy;
            words_out = words_out + (accepted ? 1 : 0) - (o_done ? 1 : 0);
            nxt_start = start && !accepted;
            nxt_we    = 1'b0;
            if (!nxt_start && !start && !busy && idle_left > 0) begin
                idle_left--;
            end else if (!nxt_start && idle_left == 0 && pending_ops.size() > 0) begin
                head = pending_ops[0];
                case (head.kind)
                    OP_WORD: begin
                        nxt_start = 1'b1;
                        i_mode    <= head.mode;
                        i_key     <= head.key;
                        i_value   <= head.value;
                        idle_left = head.idle;
                        void'(pending_ops.pop_front());
                    end
                    OP_CAPACITY: begin
                        if (words_out == 0 && !start && !busy) begin
                            nxt_we = 1'b1;
                            i_cfg_wdata <= head.cap;
                            void'(pending_ops.pop_front());
                        end
                    end
                    default: begin
                        if (words_out == 0 && !start && !busy)
                            void'(pending_ops.pop_front());
                    end
                endcase
            end
            start    <= nxt_start;
            i_cfg_we <= nxt_we;
        end
    end

    // Monitor: checks each result word first, then predicts any word taken at this edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_done) begin
                check_result();
                hit_count   += o_hit ? 1 : 0;
                evict_count += o_evicted ? 1 : 0;
            end
            if (start && !busy) begin
                pending_results.push_back(predict_access(i_mode, i_key, i_value));
                if (i_mode == lfu_pkg::MODE_GET)
                    get_count++;
                else
                    put_count++;
            end
            if (i_cfg_we)
                cache_capacity = i_cfg_wdata;
        end
    end

    initial begin
        int  n;
        bit  timed_out;
        for (n = 0; n < SLOTS; n++)
            slot_valid[n] = 1'b0;
        for (n = 0; n < 20; n++)
            key_pool[n] = $urandom;

        // Directed: extreme keys and data, hits, updates, misses.
        queue_word(lfu_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0, 0);
        queue_word(lfu_pkg::MODE_PUT, 32'h7FFF_FFFF, 32'h8000_0000, 0);
        queue_word(lfu_pkg::MODE_PUT, 32'h8000_0000, 32'h7FFF_FFFF, 2);
        queue_word(lfu_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0000, 0);
        queue_word(lfu_pkg::MODE_PUT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5);
        queue_word(lfu_pkg::MODE_GET, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0);
        queue_word(lfu_pkg::MODE_GET, 32'h8000_0000, 32'h0, 1);
        queue_word(lfu_pkg::MODE_GET, 32'h0000_0000, 32'h0, 0);
        queue_word(lfu_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0, 0);
        queue_word(lfu_pkg::MODE_PUT, 32'h0000_0000, 32'h55AA_33CC, 0);
        queue_word(lfu_pkg::MODE_GET, 32'h0000_0000, 32'h0, 0);
        queue_word(lfu_pkg::MODE_GET, 32'h0000_0001, 32'h0, 0);
        // Capacity dropped below the number of stored entries.
        queue_control(OP_CAPACITY, 5'd1);
        queue_word(lfu_pkg::MODE_PUT, 32'h0000_0002, 32'h1234_5678, 0);
        queue_word(lfu_pkg::MODE_GET, 32'h7FFF_FFFF, 32'h0, 0);
        queue_word(lfu_pkg::MODE_PUT, 32'h0000_0003, 32'hCAFE_0003, 3);
        // Zero capacity ignores every put, even one to a stored key.
        queue_control(OP_CAPACITY, 5'd0);
        queue_word(lfu_pkg::MODE_PUT, 32'h0000_0000, 32'h0000_0009, 0);
        queue_word(lfu_pkg::MODE_PUT, 32'h0000_0004, 32'h0000_0004, 0);
        queue_word(lfu_pkg::MODE_GET, 32'h0000_0000, 32'h0, 0);

        // Capacity above the slot count behaves as a full-size cache.
        queue_control(OP_CAPACITY, 5'd31);
        queue_random_words(200, 20, 1'b1);
        queue_random_words(150, 20, 1'b0);
        queue_control(OP_DRAIN, '0);

        queue_control(OP_CAPACITY, 5'd1);
        queue_random_words(150, 3, 1'b1);
        queue_control(OP_CAPACITY, 5'd2);
        queue_random_words(150, 4, $urandom_range(0, 1));
        queue_control(OP_CAPACITY, 5'd5);
        queue_random_words(200, 8, 1'b1);
        queue_control(OP_CAPACITY, 5'd17);
        queue_random_words(200, 20, $urandom_range(0, 1));
        queue_control(OP_CAPACITY, 5'd0);
        queue_random_words(100, 20, 1'b1);
        queue_control(OP_CAPACITY, 5'd8);
        queue_random_words(200, 12, 1'b1);
        queue_control(OP_CAPACITY, 5'($urandom_range(0, 31)));
        queue_random_words(150, 20, $urandom_range(0, 1));
        queue_control(OP_CAPACITY, 5'd16);
        queue_random_words(300, 20, 1'b0);

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        timed_out = 1'b0;
        while (!(pending_ops.size() == 0 && !start && words_out == 0 &&
                 pending_results.size() == 0) && !timed_out) begin
            @(negedge i_clk);
            timed_out = (cycle_count >= CYCLE_LIMIT);
        end

        if (timed_out) begin
            $display("Timed out after %0d cycles with %0d words still outstanding",
                     cycle_count, pending_results.size());
            $display("CHECK FAILED");
        end else begin
            repeat (TAIL_CYCLES) @(posedge i_clk);
            if (pending_results.size() != 0)
                flag_mismatch($sformatf("%0d result words never arrived",
                                        pending_results.size()));
            $display("Ran %0d gets and %0d puts over %0d capacity settings.",
                     get_count, put_count, setting_count);
            $display("Saw %0d hits and %0d evictions, %0d mismatches.",
                     hit_count, evict_count, mismatches);
            if (mismatches == 0)
                $display("CHECK OK");
            else
                $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
